/* rtl/lcm_pkg.sv */
// Shared types and constants for the load cell channel monitor.
// No dependencies; every other file of the block imports this package.
package lcm_pkg;

  localparam int unsigned LIMIT_W      = 23;
  localparam int unsigned SPEED_W      = 16;
  localparam int unsigned STEADY_W     = 4;
  localparam int unsigned STEADY_CNT_W = 5;
  localparam int unsigned APB_ADDR_W   = 5;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned REG_IDX_W    = 3;

  localparam logic [STEADY_CNT_W-1:0] STEADY_MAX = 5'd31;

  localparam logic [LIMIT_W-1:0]  SAFE_LIMIT_RST    = '0;
  localparam logic [LIMIT_W-1:0]  MAX_LIMIT_RST     = '0;
  localparam logic [LIMIT_W-1:0]  ZERO_LIMIT_RST    = '0;
  localparam logic [SPEED_W-1:0]  SPEED_LIMIT_RST   = 16'd128;
  localparam logic [STEADY_W-1:0] STEADY_NEEDED_RST = 4'd5;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAFE_LIMIT    = 3'd0,
    REG_MAX_LIMIT     = 3'd1,
    REG_ZERO_LIMIT    = 3'd2,
    REG_SPEED_LIMIT   = 3'd3,
    REG_STEADY_NEEDED = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_SAMPLE     = 1'b0,
    CMD_ZERO_CHECK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    LOAD_NORMAL     = 2'd0,
    LOAD_OVERWEIGHT = 2'd1,
    LOAD_DAMAGED    = 2'd2
  } load_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  safe_limit;
    logic [LIMIT_W-1:0]  max_limit;
    logic [LIMIT_W-1:0]  zero_limit;
    logic [SPEED_W-1:0]  speed_limit;
    logic [STEADY_W-1:0] steady_needed;
  } cfg_t;

endpackage

/* rtl/lcm_cfg_regs.sv */
// APB-style configuration register bank for the load cell channel monitor.
// Depends on lcm_pkg for register indexes, reset values and the cfg_t bundle.
module lcm_cfg_regs
  import lcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t           cfg_r;
  cfg_t           cfg_nxt;
  logic           wr_en;
  reg_idx_t       idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SAFE_LIMIT:    cfg_nxt.safe_limit    = pwdata[LIMIT_W-1:0];
        REG_MAX_LIMIT:     cfg_nxt.max_limit     = pwdata[LIMIT_W-1:0];
        REG_ZERO_LIMIT:    cfg_nxt.zero_limit    = pwdata[LIMIT_W-1:0];
        REG_SPEED_LIMIT:   cfg_nxt.speed_limit   = pwdata[SPEED_W-1:0];
        REG_STEADY_NEEDED: cfg_nxt.steady_needed = pwdata[STEADY_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAFE_LIMIT:    prdata = APB_DATA_W'(cfg_r.safe_limit);
      REG_MAX_LIMIT:     prdata = APB_DATA_W'(cfg_r.max_limit);
      REG_ZERO_LIMIT:    prdata = APB_DATA_W'(cfg_r.zero_limit);
      REG_SPEED_LIMIT:   prdata = APB_DATA_W'(cfg_r.speed_limit);
      REG_STEADY_NEEDED: prdata = APB_DATA_W'(cfg_r.steady_needed);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_limit    <= SAFE_LIMIT_RST;
      cfg_r.max_limit     <= MAX_LIMIT_RST;
      cfg_r.zero_limit    <= ZERO_LIMIT_RST;
      cfg_r.speed_limit   <= SPEED_LIMIT_RST;
      cfg_r.steady_needed <= STEADY_NEEDED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/lcm_div_trunc.sv */
// Signed division of a window sum by a constant sample count, truncating toward zero.
// Shift with rounding bias for powers of two, reciprocal multiply otherwise; uses lcm_pkg.
module lcm_div_trunc
  import lcm_pkg::*;
#(
  parameter int unsigned SUM_W   = 26,
  parameter int unsigned QUO_W   = 24,
  parameter int unsigned DIVISOR = 4
) (
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [QUO_W-1:0] quo
);

  localparam bit          IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);
  localparam int unsigned SHIFT   = $clog2(DIVISOR);

  generate
    if (IS_POW2) begin : g_shift
      logic signed [SUM_W-1:0] bias;
      logic signed [SUM_W-1:0] adj;
      logic signed [SUM_W-1:0] shifted;

      assign bias    = sum[SUM_W-1] ? SUM_W'(DIVISOR - 1) : '0;
      assign adj     = sum + bias;
      assign shifted = adj >>> SHIFT;
      assign quo     = shifted[QUO_W-1:0];
    end else begin : g_recip
      localparam int unsigned K     = SUM_W + SHIFT;
      localparam int unsigned PROD_W = 2 * SUM_W + 1;
      localparam logic [63:0] RECIP64 = ((64'd1 << K) + DIVISOR - 1) / DIVISOR;
      localparam logic [SUM_W:0] RECIP = RECIP64[SUM_W:0];

      logic              neg;
      logic [SUM_W-1:0]  mag;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] qfull;
      logic [QUO_W-1:0]  qmag;

      assign neg   = sum[SUM_W-1];
      assign mag   = neg ? (~sum + 1'b1) : sum;
      assign prod  = PROD_W'(mag) * PROD_W'(RECIP);
      assign qfull = prod >> K;
      assign qmag  = qfull[QUO_W-1:0];
      assign quo   = neg ? (~qmag + 1'b1) : qmag;
    end
  endgenerate

endmodule

/* rtl/lcm_channel_core.sv */
// Per-channel state and the single-pass update for one registered item.
// Depends on lcm_pkg and lcm_div_trunc.
module lcm_channel_core
  import lcm_pkg::*;
#(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned AVG_SAMPLES = 4,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned CHW         = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          upd,
  input  logic                          valid,
  input  cmd_t                          cmd,
  input  logic [CHW-1:0]                channel,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          res_hit,
  output logic signed [SAMPLE_BITS-1:0] res_average,
  output load_t                         res_load,
  output logic                          res_fault,
  output logic                          res_stable
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SUM_W  = SB + $clog2(AVG_SAMPLES);
  localparam int unsigned CNT_W  = $clog2(AVG_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES - 1);
  localparam int unsigned AW     = (SB + 1 > LIMIT_W + 1) ? SB + 1 : LIMIT_W + 1;
  localparam int unsigned DW     = (SB + 2 > SPEED_W + 1) ? SB + 2 : SPEED_W + 1;
  localparam logic [CHW:0] CH_END = (CHW + 1)'(CHANNELS);

  logic signed [SUM_W-1:0] sum_r    [CHANNELS];
  logic [CNT_W-1:0]        cnt_r    [CHANNELS];
  logic signed [SB-1:0]    last_r   [CHANNELS];
  logic [STEADY_CNT_W-1:0] steady_r [CHANNELS];
  logic                    stable_r [CHANNELS];
  load_t                   load_r   [CHANNELS];
  logic                    fault_r  [CHANNELS];

  logic                    in_range;
  logic                    is_sample;
  logic                    win_done;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SB-1:0]    avg;
  logic signed [AW-1:0]    avg_ext;
  logic [AW-1:0]           avg_mag;
  logic signed [AW-1:0]    smp_ext;
  logic [AW-1:0]           smp_mag;
  logic signed [DW-1:0]    delta;
  logic [DW-1:0]           delta_mag;
  logic                    fault_nxt;
  load_t                   load_nxt;
  logic                    stable_nxt;
  logic [STEADY_CNT_W-1:0] steady_nxt;
  logic [STEADY_CNT_W-1:0] steady_inc;

  assign in_range  = valid && ({1'b0, channel} < CH_END);
  assign is_sample = (cmd == CMD_SAMPLE);
  assign win_done  = is_sample && (cnt_r[channel] == CNT_LAST);
  assign res_hit   = in_range && (!is_sample || win_done);

  assign sum_new = sum_r[channel] + SUM_W'(sample);

  lcm_div_trunc #(
    .SUM_W   (SUM_W),
    .QUO_W   (SB),
    .DIVISOR (AVG_SAMPLES)
  ) u_div (
    .sum (sum_new),
    .quo (avg)
  );

  assign avg_ext   = AW'(avg);
  assign avg_mag   = avg_ext[AW-1] ? (~avg_ext + 1'b1) : avg_ext;
  assign smp_ext   = AW'(sample);
  assign smp_mag   = smp_ext[AW-1] ? (~smp_ext + 1'b1) : smp_ext;
  assign delta     = DW'(last_r[channel]) - DW'(avg);
  assign delta_mag = delta[DW-1] ? (~delta + 1'b1) : delta;
  assign fault_nxt = smp_mag > AW'(cfg.zero_limit);
  assign steady_inc = (steady_r[channel] < STEADY_MAX) ? steady_r[channel] + 1'b1
                                                       : steady_r[channel];

  always_comb begin
    if (avg_mag > AW'(cfg.safe_limit)) begin
      load_nxt = (avg_mag > AW'(cfg.max_limit)) ? LOAD_DAMAGED : LOAD_OVERWEIGHT;
    end else begin
      load_nxt = LOAD_NORMAL;
    end
  end

  always_comb begin
    stable_nxt = stable_r[channel];
    steady_nxt = steady_r[channel];
    if (delta_mag > DW'(cfg.speed_limit)) begin
      stable_nxt = 1'b0;
      steady_nxt = '0;
    end else if (!stable_r[channel]) begin
      steady_nxt = steady_inc;
      stable_nxt = steady_inc > STEADY_CNT_W'(cfg.steady_needed);
    end
  end

  always_comb begin
    if (is_sample) begin
      res_average = avg;
      res_load    = load_nxt;
      res_fault   = fault_r[channel];
      res_stable  = stable_nxt;
    end else begin
      res_average = last_r[channel];
      res_load    = load_r[channel];
      res_fault   = fault_nxt;
      res_stable  = stable_r[channel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]    <= '0;
        cnt_r[i]    <= '0;
        last_r[i]   <= '0;
        steady_r[i] <= '0;
        stable_r[i] <= 1'b0;
        load_r[i]   <= LOAD_NORMAL;
        fault_r[i]  <= 1'b0;
      end
    end else if (upd && in_range) begin
      if (!is_sample) begin
        fault_r[channel] <= fault_nxt;
      end else if (win_done) begin
        sum_r[channel]    <= '0;
        cnt_r[channel]    <= '0;
        last_r[channel]   <= avg;
        load_r[channel]   <= load_nxt;
        stable_r[channel] <= stable_nxt;
        steady_r[channel] <= steady_nxt;
      end else begin
        sum_r[channel] <= sum_new;
        cnt_r[channel] <= cnt_r[channel] + 1'b1;
      end
    end
  end

endmodule

/* rtl/load_cell_channel_monitor_unit.sv */
// Top level of the load cell channel monitor: input register, output register, handshakes.
// Depends on lcm_pkg, lcm_cfg_regs and lcm_channel_core.
//
// Items arrive on the in_ stream: tuser carries the command (sample or zero check),
// tdata the channel and the signed sample or zero offset. A sample item is added to
// its channel's accumulator; every AVG_SAMPLES samples the window average, load
// status and stability are updated and one result item is sent on the out_ stream.
// A zero-check item updates the channel's fault flag and always gives one result.
// Items naming a channel beyond CHANNELS are dropped without effect.
// Limits are written through the cfg_ APB port; the user must write them only while the
// block is idle, as the block does not enforce it. An accepted item loads the input
// register; when it advances, any result it produces loads the result register that
// drives out_tvalid. One item is taken per cycle unless a result is held back by a
// stalled receiver; the per-channel read-modify-write in between sets that rate.
// When the receiver stalls, the pending result is held and the next item that
// produces a result waits in the input register; items with no result still pass.
// A synchronous reset clears all channel state and both valid flags, and restores
// the register reset values.
module load_cell_channel_monitor_unit
  import lcm_pkg::*;
#(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned AVG_SAMPLES = 4,
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned IN_W  = ((CHW + SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((CHW + SAMPLE_BITS + 4 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // channel, sample_value, zero padding
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // out_channel, average, load_status, fault,
                                            // stable, zero padding
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned SB = SAMPLE_BITS;

  cfg_t                 cfg;
  logic                 s1_vld_r;
  cmd_t                 s1_cmd_r;
  logic [CHW-1:0]       s1_ch_r;
  logic signed [SB-1:0] s1_smp_r;
  logic                 out_vld_r;
  logic [OUT_W-1:0]     out_data_r;
  logic                 adv;
  logic                 res_hit;
  logic signed [SB-1:0] res_average;
  load_t                res_load;
  logic                 res_fault;
  logic                 res_stable;
  logic                 in_acc;

  lcm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lcm_channel_core #(
    .CHANNELS    (CHANNELS),
    .AVG_SAMPLES (AVG_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHW         (CHW)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .upd         (adv),
    .valid       (s1_vld_r),
    .cmd         (s1_cmd_r),
    .channel     (s1_ch_r),
    .sample      (s1_smp_r),
    .res_hit     (res_hit),
    .res_average (res_average),
    .res_load    (res_load),
    .res_fault   (res_fault),
    .res_stable  (res_stable)
  );

  assign adv        = s1_vld_r && (!res_hit || !out_vld_r || out_tready);
  assign in_tready  = !s1_vld_r || adv;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= cmd_t'(in_tuser);
      s1_ch_r  <= in_tdata[CHW-1:0];
      s1_smp_r <= in_tdata[CHW+SB-1:CHW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res_hit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_hit) begin
      out_data_r <= OUT_W'({res_stable, res_fault, res_load, res_average, s1_ch_r});
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for load_cell_channel_monitor_unit: streams sample and zero-check items,
// writes the limits over APB between phases and checks every result item.
// Depends on lcm_pkg and the RTL top level only; it predicts each result itself.
module tb;
  import lcm_pkg::*;

  localparam int CH_N = 6;
  localparam int WINDOW = 4;
  localparam int ROWS = 23;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 285;
  // First byte address past the five limit registers; writes there must be ignored.
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 5'd20;

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [23:0] avg;
    load_t              load;
    logic               fault;
    logic               stable;
  } reading_t;

  typedef struct {
    cmd_t               cmd;
    logic [2:0]         chan;
    logic signed [23:0] value;
    bit                 typed;
    reading_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // channel, sample_value, zero padding
  logic                  in_tuser = 1'b0; // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;       // out_channel, average, load_status, fault,
                                          // stable, zero padding
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  load_cell_channel_monitor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [LIMIT_W-1:0]  safe_lim = SAFE_LIMIT_RST;
  logic [LIMIT_W-1:0]  max_lim = MAX_LIMIT_RST;
  logic [LIMIT_W-1:0]  zero_lim = ZERO_LIMIT_RST;
  logic [SPEED_W-1:0]  speed_lim = SPEED_LIMIT_RST;
  logic [STEADY_W-1:0] steady_req = STEADY_NEEDED_RST;

  longint      win_sum [CH_N];
  int          win_cnt [CH_N];
  longint      prev_avg [CH_N];
  int unsigned steady_run [CH_N];
  bit          settled [CH_N];
  load_t       load_state [CH_N];
  bit          fault_state [CH_N];
  longint      base_level [CH_N];

  reading_t    pending_readings [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic reading_t channel_reading(int c);
    reading_t r;
    r.chan = 3'(c);
    r.avg = 24'(prev_avg[c]);
    r.load = load_state[c];
    r.fault = fault_state[c];
    r.stable = settled[c];
    return r;
  endfunction

  function automatic bit predict_reading(cmd_t cmd, logic [2:0] chan,
                                         logic signed [23:0] value, output reading_t r);
    longint v;
    longint av;
    int c;
    v = value;
    if (chan >= CH_N) return 1'b0;
    c = int'(chan);
    if (cmd == CMD_ZERO_CHECK) begin
      fault_state[c] = magnitude(v) > zero_lim;
      r = channel_reading(c);
      return 1'b1;
    end
    win_sum[c] += v;
    win_cnt[c]++;
    if (win_cnt[c] < WINDOW) return 1'b0;
    av = win_sum[c] / WINDOW;
    win_sum[c] = 0;
    win_cnt[c] = 0;
    if (magnitude(av) > safe_lim) begin
      load_state[c] = (magnitude(av) > max_lim) ? LOAD_DAMAGED : LOAD_OVERWEIGHT;
    end else begin
      load_state[c] = LOAD_NORMAL;
    end
    if (magnitude(prev_avg[c] - av) > speed_lim) begin
      settled[c] = 1'b0;
      steady_run[c] = 0;
    end else if (!settled[c]) begin
      if (steady_run[c] < STEADY_MAX) steady_run[c]++;
      if (steady_run[c] > steady_req) settled[c] = 1'b1;
    end
    prev_avg[c] = av;
    r = channel_reading(c);
    return 1'b1;
  endfunction

  function automatic logic [31:0] cfg_value(reg_idx_t r);
    case (r)
      REG_SAFE_LIMIT:    return 32'(safe_lim);
      REG_MAX_LIMIT:     return 32'(max_lim);
      REG_ZERO_LIMIT:    return 32'(zero_lim);
      REG_SPEED_LIMIT:   return 32'(speed_lim);
      REG_STEADY_NEEDED: return 32'(steady_req);
      default:           return '0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.chan = out_tdata[2:0];
      got.avg = out_tdata[26:3];
      got.load = load_t'(out_tdata[28:27]);
      got.fault = out_tdata[29];
      got.stable = out_tdata[30];
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("result item with none expected, channel %0d", got.chan));
      end else begin
        want = pending_readings.pop_front();
        if (got.chan !== want.chan)
          report_mismatch($sformatf("channel %0d, expected %0d", got.chan, want.chan));
        if (got.avg !== want.avg)
          report_mismatch($sformatf("channel %0d average %0d, expected %0d",
                                    want.chan, got.avg, want.avg));
        if (got.load !== want.load)
          report_mismatch($sformatf("channel %0d load status %0d, expected %0d",
                                    want.chan, got.load, want.load));
        if (got.fault !== want.fault)
          report_mismatch($sformatf("channel %0d fault %0b, expected %0b",
                                    want.chan, got.fault, want.fault));
        if (got.stable !== want.stable)
          report_mismatch($sformatf("channel %0d stable %0b, expected %0b",
                                    want.chan, got.stable, want.stable));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver stalls at random, and holds off completely when asked to.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic cfg_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(reg_idx_t r);
    logic [31:0] rd;
    cfg_access(1'b0, {r, 2'b00}, '0, rd);
    if (rd !== cfg_value(r))
      report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                r.name(), rd, cfg_value(r)));
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, {r, 2'b00}, value, rd);
    case (r)
      REG_SAFE_LIMIT:    safe_lim = value[LIMIT_W-1:0];
      REG_MAX_LIMIT:     max_lim = value[LIMIT_W-1:0];
      REG_ZERO_LIMIT:    zero_lim = value[LIMIT_W-1:0];
      REG_SPEED_LIMIT:   speed_lim = value[SPEED_W-1:0];
      REG_STEADY_NEEDED: steady_req = value[STEADY_W-1:0];
      default: ;
    endcase
    check_reg(r);
  endtask

  task automatic set_limits(logic [31:0] s, logic [31:0] m, logic [31:0] z,
                            logic [31:0] sp, logic [31:0] n);
    cfg_write(REG_SAFE_LIMIT, s);
    cfg_write(REG_MAX_LIMIT, m);
    cfg_write(REG_ZERO_LIMIT, z);
    cfg_write(REG_SPEED_LIMIT, sp);
    cfg_write(REG_STEADY_NEEDED, n);
  endtask

  // Valid is left high after acceptance so that back-to-back items need no second drive.
  task automatic send_item(cmd_t c, logic [2:0] ch, logic signed [23:0] v,
                           bit typed, reading_t want);
    reading_t r;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {5'b0, v, ch};
    do @(posedge clk); while (!in_tready);
    if (predict_reading(c, ch, v, r)) pending_readings.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [23:0] clamp_sample(longint x);
    if (x > 8388607) return 24'sd8388607;
    if (x < -8388608) return -24'sd8388608;
    return 24'(x);
  endfunction

  function automatic longint near_limit(longint lim);
    longint s;
    s = lim + longint'($urandom_range(0, 2)) - 1;
    return $urandom_range(0, 1) ? s : -s;
  endfunction

  function automatic longint pick_level();
    case ($urandom_range(0, 3))
      0:       return near_limit(safe_lim);
      1:       return near_limit(max_lim);
      2:       return longint'($signed(24'($urandom)));
      default: return longint'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // Mostly steady windows around a per-channel level, with jumps, extremes and noise.
  task automatic random_item(output cmd_t c, output logic [2:0] ch,
                             output logic signed [23:0] v);
    int unsigned roll;
    longint x;
    longint spread;
    spread = longint'(speed_lim) / 4 + 1;
    roll = $urandom_range(0, 99);
    ch = (roll < 4) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, CH_N - 1));
    if ($urandom_range(0, 99) < 12) begin
      c = CMD_ZERO_CHECK;
      x = $urandom_range(0, 1) ? near_limit(zero_lim) : longint'($signed(24'($urandom)));
    end else begin
      c = CMD_SAMPLE;
      if (ch < CH_N && $urandom_range(0, 99) < 2) base_level[ch] = pick_level();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        x = longint'($signed(24'($urandom)));
      end else if (roll < 5) begin
        x = $urandom_range(0, 1) ? 8388607 : -8388608;
      end else begin
        x = (ch < CH_N) ? base_level[ch] : 0;
        if (roll >= 40) x += longint'($urandom_range(0, 32'(2 * spread))) - spread;
      end
    end
    v = clamp_sample(x);
  endtask

  task automatic run_phase(int n, bit with_calm, bit with_hold);
    cmd_t c;
    logic [2:0] ch;
    logic signed [23:0] v;
    reading_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      calm = with_calm && (i < n / 2);
      if (with_hold && i == n / 2) hold_req = 1'b1;
      random_item(c, ch, v);
      send_item(c, ch, v, 1'b0, none);
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    reg_idx_t r;
    stim_row_t rows [ROWS];
    logic [31:0] rd;
    foreach (load_state[i]) load_state[i] = LOAD_NORMAL;
    foreach (base_level[i]) base_level[i] = 0;
    rows = '{
      '{CMD_ZERO_CHECK, 3'd0, 24'sd0, 1'b1, '{3'd0, 24'sd0, LOAD_NORMAL, 1'b0, 1'b0}},
      '{CMD_ZERO_CHECK, 3'd1, 24'sd1, 1'b1, '{3'd1, 24'sd0, LOAD_NORMAL, 1'b1, 1'b0}},
      '{CMD_ZERO_CHECK, 3'd2, -24'sd8388608, 1'b1,
        '{3'd2, 24'sd0, LOAD_NORMAL, 1'b1, 1'b0}},
      '{CMD_SAMPLE, 3'd3, 24'sd8388607, 1'b0, '0},
      '{CMD_SAMPLE, 3'd3, 24'sd8388607, 1'b0, '0},
      '{CMD_SAMPLE, 3'd3, 24'sd8388607, 1'b0, '0},
      '{CMD_SAMPLE, 3'd3, 24'sd8388607, 1'b1,
        '{3'd3, 24'sd8388607, LOAD_DAMAGED, 1'b0, 1'b0}},
      '{CMD_SAMPLE, 3'd4, -24'sd8388608, 1'b0, '0},
      '{CMD_SAMPLE, 3'd4, -24'sd8388608, 1'b0, '0},
      '{CMD_SAMPLE, 3'd4, -24'sd8388608, 1'b0, '0},
      '{CMD_SAMPLE, 3'd4, -24'sd8388608, 1'b1,
        '{3'd4, -24'sd8388608, LOAD_DAMAGED, 1'b0, 1'b0}},
      '{CMD_SAMPLE, 3'd5, 24'sd1, 1'b0, '0},
      '{CMD_SAMPLE, 3'd5, 24'sd0, 1'b0, '0},
      '{CMD_SAMPLE, 3'd5, 24'sd0, 1'b0, '0},
      '{CMD_SAMPLE, 3'd5, 24'sd0, 1'b1, '{3'd5, 24'sd0, LOAD_NORMAL, 1'b0, 1'b0}},
      '{CMD_SAMPLE, 3'd5, -24'sd1, 1'b0, '0},
      '{CMD_SAMPLE, 3'd5, -24'sd1, 1'b0, '0},
      '{CMD_SAMPLE, 3'd5, -24'sd1, 1'b0, '0},
      '{CMD_SAMPLE, 3'd5, 24'sd0, 1'b1, '{3'd5, 24'sd0, LOAD_NORMAL, 1'b0, 1'b0}},
      '{CMD_SAMPLE, 3'd6, 24'sd5, 1'b0, '0},
      '{CMD_SAMPLE, 3'd7, -24'sd1, 1'b0, '0},
      '{CMD_ZERO_CHECK, 3'd7, 24'sd8388607, 1'b0, '0},
      '{CMD_ZERO_CHECK, 3'd5, 24'sd0, 1'b1, '{3'd5, 24'sd0, LOAD_NORMAL, 1'b0, 1'b0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r = r.first;
    do begin
      check_reg(r);
      r = r.next;
    end while (r != r.first);

    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].chan, rows[i].value, rows[i].typed, rows[i].want);
    drain();

    set_limits(32'd1000, 32'd100000, 32'd50, 32'd200, 32'd3);
    run_phase(PHASE_ITEMS, 1'b1, 1'b1);

    set_limits('1, '1, '1, '1, '1);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    set_limits('0, '0, '0, '0, '0);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    cfg_access(1'b1, SPARE_ADDR, '1, rd);
    r = r.first;
    do begin
      check_reg(r);
      r = r.next;
    end while (r != r.first);
    set_limits($urandom_range(0, 2000000), $urandom_range(0, 8388607),
               $urandom_range(0, 100000), $urandom_range(0, 65535), $urandom_range(0, 15));
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    set_limits($urandom_range(0, 8388607), $urandom_range(0, 2000000),
               $urandom_range(0, 8388607), $urandom_range(0, 1000), $urandom_range(0, 15));
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lcm_pkg.sv
rtl/lcm_cfg_regs.sv
rtl/lcm_div_trunc.sv
rtl/lcm_channel_core.sv
rtl/load_cell_channel_monitor_unit.sv
test/tb.sv
